// File: hdl/gbe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Geohash bisection encoder package
// Shared constants and register index codes for the encoder and its cells.
// ----------------------------------------------------------------------------
package gbe_pkg;

    // Default geometry of the encoder.
    localparam int DEF_COORD_WIDTH   = 32;
    localparam int DEF_MAX_CODE_BITS = 64;

    // Extra fraction bits carried on every bound; no axis is halved more often.
    localparam int FRAC_BITS = 32;

    // Width of the code length register and its reset value.
    localparam int               LEN_W           = 7;
    localparam logic [LEN_W-1:0] DEF_CODE_LENGTH = 7'd52;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEST   = 3'd0,
        CFG_EAST   = 3'd1,
        CFG_SOUTH  = 3'd2,
        CFG_NORTH  = 3'd3,
        CFG_LENGTH = 3'd4
    } t_cfg_idx;

endpackage
`default_nettype wire

// File: hdl/gbe_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Geohash bisection cell
// One bisection step: within the code length, halves the longitude or latitude
// interval and shifts one code bit in; hands the whole item to the next cell.
// ----------------------------------------------------------------------------
module gbe_cell
    import gbe_pkg::*;
#(
    parameter int CELL_IDX      = 0,
    parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_en,
    input  wire                                 i_valid,
    input  wire  [LEN_W-1:0]                    i_len,
    input  wire  [COORD_WIDTH-1:0]              i_px,
    input  wire  [COORD_WIDTH-1:0]              i_py,
    input  wire  [COORD_WIDTH+FRAC_BITS-1:0]    i_xlo,
    input  wire  [COORD_WIDTH+FRAC_BITS-1:0]    i_xhi,
    input  wire  [COORD_WIDTH+FRAC_BITS-1:0]    i_ylo,
    input  wire  [COORD_WIDTH+FRAC_BITS-1:0]    i_yhi,
    input  wire  [MAX_CODE_BITS-1:0]            i_code,
    output logic                                o_valid,
    output logic [LEN_W-1:0]                    o_len,
    output logic [COORD_WIDTH-1:0]              o_px,
    output logic [COORD_WIDTH-1:0]              o_py,
    output logic [COORD_WIDTH+FRAC_BITS-1:0]    o_xlo,
    output logic [COORD_WIDTH+FRAC_BITS-1:0]    o_xhi,
    output logic [COORD_WIDTH+FRAC_BITS-1:0]    o_ylo,
    output logic [COORD_WIDTH+FRAC_BITS-1:0]    o_yhi,
    output logic [MAX_CODE_BITS-1:0]            o_code
);

    localparam int BW     = COORD_WIDTH + FRAC_BITS;
    localparam bit IS_LAT = (CELL_IDX % 2) == 1;

    logic          r_valid;
    logic [LEN_W-1:0] r_len;
    logic [COORD_WIDTH-1:0] r_px, r_py;
    logic [BW-1:0] r_xlo, r_xhi, r_ylo, r_yhi;
    logic [MAX_CODE_BITS-1:0] r_code;

    logic [BW-1:0] n_xlo, n_xhi, n_ylo, n_yhi;
    logic [MAX_CODE_BITS-1:0] n_code;

    logic [BW-1:0]          lo, hi, mid, pt;
    logic [BW:0]            sum;
    logic                   active, code_bit;

    always_comb begin
        lo     = IS_LAT ? i_ylo : i_xlo;
        hi     = IS_LAT ? i_yhi : i_xhi;
        // The exact midpoint keeps the carry of the sum as its top bit.
        sum    = {1'b0, lo} + {1'b0, hi};
        mid    = sum[BW:1];
        pt     = {(IS_LAT ? i_py : i_px), {FRAC_BITS{1'b0}}};
        code_bit = !(pt < mid);
        active = i_len > LEN_W'(CELL_IDX);

        n_xlo  = i_xlo;
        n_xhi  = i_xhi;
        n_ylo  = i_ylo;
        n_yhi  = i_yhi;
        n_code = i_code;
        if (active) begin
            n_code = {i_code[MAX_CODE_BITS-2:0], code_bit};
            if (IS_LAT) begin
                if (code_bit) n_ylo = mid;
                else          n_yhi = mid;
            end else begin
                if (code_bit) n_xlo = mid;
                else          n_xhi = mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len  <= i_len;
            r_px   <= i_px;
            r_py   <= i_py;
            r_xlo  <= n_xlo;
            r_xhi  <= n_xhi;
            r_ylo  <= n_ylo;
            r_yhi  <= n_yhi;
            r_code <= n_code;
        end
    end

    assign o_valid = r_valid;
    assign o_len   = r_len;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_xlo   = r_xlo;
    assign o_xhi   = r_xhi;
    assign o_ylo   = r_ylo;
    assign o_yhi   = r_yhi;
    assign o_code  = r_code;

`ifndef ASSERT_OFF
    // A cell past the code length leaves the code untouched.
    a_idle_cell_keeps_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid && !(i_len > LEN_W'(CELL_IDX))) |=> (o_code == $past(i_code)))
        else $error("inactive cell changed the code");

    // An active cell shifts the earlier bits up by one place.
    a_active_cell_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid && (i_len > LEN_W'(CELL_IDX)))
        |=> (o_code[MAX_CODE_BITS-1:1] == $past(i_code[MAX_CODE_BITS-2:0])))
        else $error("active cell did not shift the code");

    // Only one bound of one axis moves in a step.
    a_one_bound_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid) |=> ((o_xlo == $past(i_xlo) || o_xhi == $past(i_xhi))
                  && (o_ylo == $past(i_ylo) || o_yhi == $past(i_yhi))))
        else $error("more than one bound moved");

    // A stalled cell holds its item.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(o_valid) && $stable(o_code)))
        else $error("stalled cell lost its item");
`endif

endmodule
`default_nettype wire

// File: hdl/geohash_bisect_encoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Geohash bisection encoder
// Turns a longitude/latitude point into its interleaved geohash code inside a
// configurable bounding box, using a chain of one-step bisection cells.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  --------+-----------+----------------------------------------------------
//  in      | sink      | i_in_valid, o_in_ready, i_lon_coord, i_lat_coord
//  out     | source    | o_out_valid, i_out_ready, o_geo_code
//  cfg     | sink      | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
//  One point is taken per cycle while the chain is not stalled; a result is
//  presented once it has passed through the whole chain of bisection cells,
//  each a register, and leaves when the output side takes it.
//  The chain advances as a whole; it stalls only while the last cell holds a
//  result that the output side does not take.
//  Synchronous reset empties the chain and loads the default box and length.
//  Configuration beats are always taken.
// ----------------------------------------------------------------------------
module geohash_bisect_encoder_top
    import gbe_pkg::*;
#(
    parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire signed [COORD_WIDTH-1:0]  i_lon_coord,
    input  wire signed [COORD_WIDTH-1:0]  i_lat_coord,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [MAX_CODE_BITS-1:0]      o_geo_code,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire  [COORD_WIDTH-1:0]        i_cfg_data
);

    localparam int BW = COORD_WIDTH + FRAC_BITS;

    logic [COORD_WIDTH-1:0] r_west, r_east, r_south, r_north;
    logic [LEN_W-1:0]       r_code_length;

    logic                     c_valid [0:MAX_CODE_BITS];
    logic [LEN_W-1:0]         c_len   [0:MAX_CODE_BITS];
    logic [COORD_WIDTH-1:0]   c_px    [0:MAX_CODE_BITS];
    logic [COORD_WIDTH-1:0]   c_py    [0:MAX_CODE_BITS];
    logic [BW-1:0]            c_xlo   [0:MAX_CODE_BITS];
    logic [BW-1:0]            c_xhi   [0:MAX_CODE_BITS];
    logic [BW-1:0]            c_ylo   [0:MAX_CODE_BITS];
    logic [BW-1:0]            c_yhi   [0:MAX_CODE_BITS];
    logic [MAX_CODE_BITS-1:0] c_code  [0:MAX_CODE_BITS];

    logic chain_en;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_west        <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
            r_east        <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
            r_south       <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
            r_north       <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
            r_code_length <= DEF_CODE_LENGTH;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WEST:   r_west        <= i_cfg_data;
                CFG_EAST:   r_east        <= i_cfg_data;
                CFG_SOUTH:  r_south       <= i_cfg_data;
                CFG_NORTH:  r_north       <= i_cfg_data;
                CFG_LENGTH: r_code_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Coordinates and bounds are compared as offset binary, sign bit flipped.
    assign c_valid[0] = i_in_valid;
    assign c_len[0]   = r_code_length;
    assign c_px[0]    = {~i_lon_coord[COORD_WIDTH-1], i_lon_coord[COORD_WIDTH-2:0]};
    assign c_py[0]    = {~i_lat_coord[COORD_WIDTH-1], i_lat_coord[COORD_WIDTH-2:0]};
    assign c_xlo[0]   = {~r_west[COORD_WIDTH-1], r_west[COORD_WIDTH-2:0], {FRAC_BITS{1'b0}}};
    assign c_xhi[0]   = {~r_east[COORD_WIDTH-1], r_east[COORD_WIDTH-2:0], {FRAC_BITS{1'b0}}};
    assign c_ylo[0]   = {~r_south[COORD_WIDTH-1], r_south[COORD_WIDTH-2:0],
                         {FRAC_BITS{1'b0}}};
    assign c_yhi[0]   = {~r_north[COORD_WIDTH-1], r_north[COORD_WIDTH-2:0],
                         {FRAC_BITS{1'b0}}};
    assign c_code[0]  = '0;

    // The last cell doubles as the output register.
    assign chain_en    = !c_valid[MAX_CODE_BITS] || i_out_ready;
    assign o_in_ready  = chain_en;
    assign o_out_valid = c_valid[MAX_CODE_BITS];
    assign o_geo_code  = c_code[MAX_CODE_BITS];

    for (genvar g = 0; g < MAX_CODE_BITS; g++) begin : g_cell
        gbe_cell #(
            .CELL_IDX      (g),
            .COORD_WIDTH   (COORD_WIDTH),
            .MAX_CODE_BITS (MAX_CODE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (chain_en),
            .i_valid (c_valid[g]),
            .i_len   (c_len[g]),
            .i_px    (c_px[g]),
            .i_py    (c_py[g]),
            .i_xlo   (c_xlo[g]),
            .i_xhi   (c_xhi[g]),
            .i_ylo   (c_ylo[g]),
            .i_yhi   (c_yhi[g]),
            .i_code  (c_code[g]),
            .o_valid (c_valid[g+1]),
            .o_len   (c_len[g+1]),
            .o_px    (c_px[g+1]),
            .o_py    (c_py[g+1]),
            .o_xlo   (c_xlo[g+1]),
            .o_xhi   (c_xhi[g+1]),
            .o_ylo   (c_ylo[g+1]),
            .o_yhi   (c_yhi[g+1]),
            .o_code  (c_code[g+1])
        );
    end

`ifndef ASSERT_OFF
    // Reset leaves no result pending.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A zero length point comes out as an all-zero code.
    a_zero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && c_len[MAX_CODE_BITS] == '0) |-> (o_geo_code == '0))
        else $error("zero length gave a nonzero code");

    // Input is refused only while a result waits at the output.
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input refused without output backpressure");
`endif

endmodule
`default_nettype wire

// File: dv/geohash_bisect_encoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Geohash bisection encoder testbench
// Drives points through the encoder under a series of bounding boxes and
// code lengths, and checks every code against a table value or a bit-exact
// bisection predictor. A short stimulus table covers the extremes and the corner
// cases. Randomized phases follow, with idle cycles on both sides and one long output stall.
// ----------------------------------------------------------------------------
module geohash_bisect_encoder_top_tb
    import gbe_pkg::*;
();

    localparam int CW          = DEF_COORD_WIDTH;
    localparam int MCB         = DEF_MAX_CODE_BITS;
    localparam int BW          = CW + FRAC_BITS;
    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;
    localparam int N_PHASES    = 11;
    localparam int PHASE_ITEMS = 50;
    localparam int LEN_MAX     = 2**LEN_W - 1;

    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] COORD_MAX = ~COORD_MIN;

    // Indexes that map to no register; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic {
        ROW_CFG,
        ROW_POINT
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CW-1:0]          data;
        logic [CW-1:0]          lon;
        logic [CW-1:0]          lat;
        logic                   typed;
        logic [MCB-1:0]         code;
    } t_stim_row;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   pt_valid     = 1'b0;
    logic [CW-1:0]          pt_lon       = '0;
    logic [CW-1:0]          pt_lat       = '0;
    logic                   pt_typed     = 1'b0;
    logic [MCB-1:0]         pt_code      = '0;
    logic                   code_ready   = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [CW-1:0]          cfg_data     = '0;
    wire                    o_in_ready;
    wire                    o_out_valid;
    wire [MCB-1:0]          o_geo_code;
    wire                    o_cfg_ready;

    // Encoder settings as the predictor sees them.
    logic [CW-1:0]          west_q, east_q, south_q, north_q;
    logic [LEN_W-1:0]       len_q;

    logic [MCB-1:0]         pending_codes [$];
    logic [MCB-1:0]         want_code;
    t_stim_row              dir_rows [$];
    int                     points_sent  = 0;
    int                     codes_seen   = 0;
    int                     err_count    = 0;
    int                     cycle_count  = 0;
    int                     hold_left    = 0;
    bit                     hold_req     = 1'b0;
    bit                     hold_taken   = 1'b0;
    bit                     steady       = 1'b0;

    geohash_bisect_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (pt_valid),
        .o_in_ready  (o_in_ready),
        .i_lon_coord (pt_lon),
        .i_lat_coord (pt_lat),
        .o_out_valid (o_out_valid),
        .i_out_ready (code_ready),
        .o_geo_code  (o_geo_code),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Signed coordinate to an unsigned position with 32 zero fraction bits.
    function automatic logic [BW-1:0] to_fixed(logic [CW-1:0] v);
        return {~v[CW-1], v[CW-2:0], {FRAC_BITS{1'b0}}};
    endfunction

    function automatic logic [MCB-1:0] geohash_of(logic [CW-1:0] lon, logic [CW-1:0] lat);
        logic [BW-1:0] x_lo, x_hi, y_lo, y_hi, px, py, mid;
        logic [BW:0]   total;
        logic [MCB-1:0] code;
        int            bits;
        int            i;
        x_lo = to_fixed(west_q);
        x_hi = to_fixed(east_q);
        y_lo = to_fixed(south_q);
        y_hi = to_fixed(north_q);
        px   = to_fixed(lon);
        py   = to_fixed(lat);
        bits = (int'(len_q) > MCB) ? MCB : int'(len_q);
        code = '0;
        for (i = 0; i < bits; i++) begin
            if (i % 2 == 0) begin
                total = {1'b0, x_lo} + {1'b0, x_hi};
                mid   = total[BW:1];
                if (px < mid) begin
                    code = {code[MCB-2:0], 1'b0};
                    x_hi = mid;
                end else begin
                    code = {code[MCB-2:0], 1'b1};
                    x_lo = mid;
                end
            end else begin
                total = {1'b0, y_lo} + {1'b0, y_hi};
                mid   = total[BW:1];
                if (py < mid) begin
                    code = {code[MCB-2:0], 1'b0};
                    y_hi = mid;
                end else begin
                    code = {code[MCB-2:0], 1'b1};
                    y_lo = mid;
                end
            end
        end
        return code;
    endfunction

    function automatic t_stim_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.data  = data;
        return row;
    endfunction

    function automatic t_stim_row pt_row(logic [CW-1:0] lon, logic [CW-1:0] lat);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_POINT;
        row.lon   = lon;
        row.lat   = lat;
        return row;
    endfunction

    function automatic t_stim_row chk_row(logic [CW-1:0] lon, logic [CW-1:0] lat,
                                          logic [MCB-1:0] code);
        t_stim_row row;
        row       = pt_row(lon, lat);
        row.typed = 1'b1;
        row.code  = code;
        return row;
    endfunction

    // Uniform value between two signed bounds, given in either order.
    function automatic logic [CW-1:0] rand_between(logic signed [CW-1:0] a,
                                                   logic signed [CW-1:0] b);
        longint     lo, hi;
        logic [63:0] span, pick;
        lo   = (a < b) ? a : b;
        hi   = (a < b) ? b : a;
        span = hi - lo + 1;
        pick = lo + ({$urandom, $urandom} % span);
        return pick[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] pick_coord(logic [CW-1:0] lo, logic [CW-1:0] hi);
        int            sel;
        logic [CW-1:0] v;
        sel = $urandom_range(99);
        if (sel < 45) begin
            v = rand_between(lo, hi);
        end else if (sel < 70) begin
            v = $urandom;
        end else if (sel < 85) begin
            v = (sel % 2 == 0 ? lo : hi) + CW'($urandom_range(0, 6)) - CW'(3);
        end else begin
            case ($urandom_range(3))
                0: v = COORD_MIN;
                1: v = COORD_MAX;
                2: v = '0;
                default: v = '1;
            endcase
        end
        return v;
    endfunction

    task automatic send_point(input logic [CW-1:0] lon, input logic [CW-1:0] lat,
                              input logic typed, input logic [MCB-1:0] code);
        cfg_valid <= 1'b0;
        if (!steady && $urandom_range(99) < 14) begin
            pt_valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_valid <= 1'b1;
        pt_lon   <= lon;
        pt_lat   <= lat;
        pt_typed <= typed;
        pt_code  <= code;
        do @(posedge i_clk); while (!o_in_ready);
        points_sent++;
    endtask

    // Registers change only with the encoder empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
        pt_valid <= 1'b0;
        while (codes_seen != points_sent) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Output side: random back-pressure plus one long hold that backs up the chain.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            code_ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            code_ready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            code_ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            west_q  = COORD_MIN;
            east_q  = COORD_MAX;
            south_q = COORD_MIN;
            north_q = COORD_MAX;
            len_q   = DEF_CODE_LENGTH;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    CFG_WEST:   west_q  = cfg_data;
                    CFG_EAST:   east_q  = cfg_data;
                    CFG_SOUTH:  south_q = cfg_data;
                    CFG_NORTH:  north_q = cfg_data;
                    CFG_LENGTH: len_q   = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (pt_valid && o_in_ready)
                pending_codes.push_back(pt_typed ? pt_code : geohash_of(pt_lon, pt_lat));
            if (o_out_valid && code_ready) begin
                codes_seen <= codes_seen + 1;
                if (pending_codes.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected geo_code %h with nothing pending", o_geo_code);
                end else begin
                    want_code = pending_codes.pop_front();
                    if (o_geo_code !== want_code) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("geo_code mismatch: expected %h, got %h",
                                     want_code, o_geo_code);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int               ph, k, sel;
        logic [CW-1:0]    w, e, s, n, mid, swap;
        logic [LEN_W-1:0] len;

        dir_rows = {
            // Reset box and length: the corners read off directly.
            chk_row(COORD_MAX, COORD_MAX, 64'h000F_FFFF_FFFF_FFFF),
            chk_row(COORD_MIN, COORD_MIN, 64'h0),
            chk_row(COORD_MAX, COORD_MIN, 64'h000A_AAAA_AAAA_AAAA),
            chk_row(COORD_MIN, COORD_MAX, 64'h0005_5555_5555_5555),
            pt_row(32'h0000_0000, 32'h0000_0000),
            pt_row(32'hFFFF_FFFF, 32'hFFFF_FFFF),
            cfg_row(CFG_LENGTH, MCB),
            chk_row(COORD_MAX, COORD_MAX, 64'hFFFF_FFFF_FFFF_FFFF),
            chk_row(COORD_MAX, COORD_MIN, 64'hAAAA_AAAA_AAAA_AAAA),
            pt_row(32'h1234_5678, 32'h9ABC_DEF0),
            // A length beyond the code width is clipped to the full width.
            cfg_row(CFG_LENGTH, LEN_MAX),
            chk_row(COORD_MAX, COORD_MAX, 64'hFFFF_FFFF_FFFF_FFFF),
            pt_row(32'hDEAD_BEEF, 32'h0BAD_F00D),
            cfg_row(CFG_LENGTH, 32'h0),
            chk_row(COORD_MAX, COORD_MAX, 64'h0),
            chk_row(COORD_MIN, 32'h1234_5678, 64'h0),
            cfg_row(CFG_LENGTH, 32'h1),
            chk_row(COORD_MAX, COORD_MIN, 64'h1),
            chk_row(COORD_MIN, COORD_MAX, 64'h0),
            // Only the low seven data bits reach the length register.
            cfg_row(CFG_LENGTH, 32'hFFFF_FF94),
            pt_row(32'h0000_0000, 32'h0000_0000),
            cfg_row(CFG_SPARE_LO, 32'h0000_0000),
            cfg_row(CFG_SPARE_HI, 32'hFFFF_FFFF),
            chk_row(COORD_MAX, COORD_MAX, 64'h0000_0000_000F_FFFF),
            // Small box; the first point lies east and south of it.
            cfg_row(CFG_WEST, 32'hFFFF_FF9C),
            cfg_row(CFG_EAST, 32'd100),
            cfg_row(CFG_SOUTH, 32'd0),
            cfg_row(CFG_NORTH, 32'd8),
            cfg_row(CFG_LENGTH, 32'd16),
            chk_row(32'd1000, 32'hFFFF_FFCE, 64'hAAAA),
            pt_row(32'd4, 32'd4),
            pt_row(32'hFFFF_FF9C, 32'd8),
            // Minimum above maximum on both axes.
            cfg_row(CFG_WEST, 32'd100),
            cfg_row(CFG_EAST, 32'hFFFF_FF9C),
            cfg_row(CFG_SOUTH, 32'd8),
            cfg_row(CFG_NORTH, 32'd0),
            pt_row(32'd0, 32'd0),
            pt_row(32'd50, 32'd7),
            pt_row(COORD_MIN, COORD_MAX),
            // Box collapsed to a single point.
            cfg_row(CFG_WEST, 32'd5),
            cfg_row(CFG_EAST, 32'd5),
            cfg_row(CFG_SOUTH, 32'hFFFF_FFFB),
            cfg_row(CFG_NORTH, 32'hFFFF_FFFB),
            cfg_row(CFG_LENGTH, MCB),
            pt_row(32'd5, 32'hFFFF_FFFB),
            pt_row(32'd6, 32'hFFFF_FFFA)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG)
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            else
                send_point(dir_rows[r].lon, dir_rows[r].lat, dir_rows[r].typed,
                           dir_rows[r].code);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            w   = $urandom;
            e   = $urandom;
            s   = $urandom;
            n   = $urandom;
            sel = $urandom_range(99);
            len = (sel < 70) ? LEN_W'($urandom_range(1, MCB))
                             : LEN_W'($urandom_range(0, LEN_MAX));
            case (ph)
                0: begin
                    w = COORD_MIN; e = COORD_MAX; s = COORD_MIN; n = COORD_MAX;
                    len = LEN_W'(MCB);
                end
                1: begin
                    w = COORD_MIN; e = COORD_MAX; s = COORD_MIN; n = COORD_MAX;
                end
                2: begin
                    // Narrow spans let some midpoints land exactly on integer points.
                    mid = $urandom;
                    w   = mid - CW'($urandom_range(0, 32));
                    e   = mid + CW'($urandom_range(0, 32));
                    mid = $urandom;
                    s   = mid - CW'($urandom_range(0, 32));
                    n   = mid + CW'($urandom_range(0, 32));
                    len = LEN_W'(MCB);
                end
                3: begin
                    if ($signed(w) < $signed(e)) begin
                        swap = w; w = e; e = swap;
                    end
                    if ($signed(s) < $signed(n)) begin
                        swap = s; s = n; n = swap;
                    end
                end
                4: begin
                    e   = w;
                    n   = s;
                    len = LEN_W'(MCB);
                end
                default: begin
                    if ($signed(w) > $signed(e) && $urandom_range(99) < 80) begin
                        swap = w; w = e; e = swap;
                    end
                    if ($signed(s) > $signed(n) && $urandom_range(99) < 80) begin
                        swap = s; s = n; n = swap;
                    end
                end
            endcase

            write_reg(CFG_WEST, w);
            write_reg(CFG_EAST, e);
            write_reg(CFG_SOUTH, s);
            write_reg(CFG_NORTH, n);
            write_reg(CFG_LENGTH, ($urandom & ~CW'(LEN_MAX)) | CW'(len));

            steady <= (ph == 5);
            if (ph == 2)
                hold_req <= 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
                send_point(pick_coord(w, e), pick_coord(s, n), 1'b0, '0);
        end

        pt_valid <= 1'b0;
        while (codes_seen != points_sent) @(posedge i_clk);
        repeat (2 * MCB) @(posedge i_clk);
        err_count += pending_codes.size();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
